// File: src/wpps_pkg.sv
package wpps_pkg;

  // Default sizes handed to the top level's parameters.
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_JOB_COUNT   = 16;

  // Field widths of the transactions and of the ordering key.
  localparam int JOB_W    = 4;
  localparam int BURST_W  = 12;
  localparam int PRIO_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int TIME_W   = 16;
  localparam int WAIT_W   = 16;
  // A 12-bit burst times a signed 16-bit weight needs 28 bits; the sum of two
  // such products needs one more.
  localparam int KEY_W    = 29;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

  // Item kinds carried in the mode field.
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_WEIGHT_BURST = 1'b0;
  localparam logic CFG_WEIGHT_PRIO  = 1'b1;

  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_SERVED  = 2'd2,
    ST_IDLE    = 2'd3
  } status_e;

  typedef struct packed {
    logic               mode;
    logic [JOB_W-1:0]   job_id;
    logic [BURST_W-1:0] burst_len;
    logic [PRIO_W-1:0]  job_priority;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [JOB_W-1:0]   served_id;
    logic               job_done;
    logic [WAIT_W-1:0]  wait_total;
    logic [TIME_W-1:0]  end_time;
    logic               new_segment;
  } out_item_t;

  // One ready queue entry.
  typedef struct packed {
    logic [JOB_W-1:0]   job;
    logic [BURST_W-1:0] rem;
    logic [PRIO_W-1:0]  prio;
  } qentry_t;

  // Control of the shared key multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

// File: src/weighted_priority_preemptive_scheduler_core.sv
// Sequence: an arrival computes its key, compares it with queue entries from the head and
// shifts the entries behind the insertion point back before inserting; a serving tick reads
// the head entry and then the per-job stores; a dropped arrival or an idle tick goes straight
// to its result; each may wait for an unread result. One transaction at a time, the next taken
// in the cycle after the result is loaded. Reset clears the queue,
// the time and the waiting totals at once (valid bits, no clearing pass); weights become 1.0.
module weighted_priority_preemptive_scheduler_core #(
  parameter int QUEUE_DEPTH = wpps_pkg::DEF_QUEUE_DEPTH,
  parameter int JOB_COUNT   = wpps_pkg::DEF_JOB_COUNT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [wpps_pkg::WEIGHT_W-1:0]   cfg_data_i,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wpps_pkg::in_item_t              in_data_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wpps_pkg::out_item_t             out_data_o
);

  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int JIW = (JOB_COUNT > 1) ? $clog2(JOB_COUNT) : 1;

  // The sequencer. Arrivals walk the key scan and the shift; ticks read the
  // head entry and then the per-job stores.
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_NKEY0 = 14'b00000000000010,
    S_NKEY1 = 14'b00000000000100,
    S_NKEY2 = 14'b00000000001000,
    S_SMUL0 = 14'b00000000010000,
    S_SMUL1 = 14'b00000000100000,
    S_SCMP  = 14'b00000001000000,
    S_SHRD  = 14'b00000010000000,
    S_SHWR  = 14'b00000100000000,
    S_INS   = 14'b00001000000000,
    S_TRD   = 14'b00010000000000,
    S_TJOB  = 14'b00100000000000,
    S_TUPD  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // The ready queue is a circular buffer: logical entry i lives at
  // (head + i) modulo the depth, so removing the head is a pointer step.
  function automatic logic [QIW-1:0] phys(input logic [QIW-1:0] h,
                                          input logic [QIW-1:0] i);
    logic [QIW:0] s;
    s = {1'b0, h} + {1'b0, i};
    if (s >= (QIW+1)'(QUEUE_DEPTH)) begin
      s = s - (QIW+1)'(QUEUE_DEPTH);
    end
    return s[QIW-1:0];
  endfunction

  wpps_pkg::in_item_t  item_q, item_d;
  logic [wpps_pkg::WEIGHT_W-1:0] wb_q, wp_q;
  logic [CW-1:0]                 count_q, count_d;
  logic [QIW-1:0]                head_q, head_d;
  logic [QIW-1:0]                pos_q, pos_d;
  logic [QIW-1:0]                j_q, j_d;
  logic [wpps_pkg::TIME_W-1:0]   time_q, time_d;
  logic [wpps_pkg::JOB_W-1:0]    prev_q, prev_d;
  logic                          any_q, any_d;
  logic signed [wpps_pkg::KEY_W-1:0] newkey_q, newkey_d;

  logic                          out_valid_q;
  wpps_pkg::out_item_t           out_q, out_d;
  logic                          out_load;
  logic                          out_free;

  // Queue memory.
  wpps_pkg::qentry_t q_mem [QUEUE_DEPTH];
  wpps_pkg::qentry_t q_rd_q;
  wpps_pkg::qentry_t q_wdata;
  logic              q_re, q_we;
  logic [QIW-1:0]    q_raddr, q_waddr;

  // Per-job stores: waiting totals (cleared through valid bits) and the time
  // each job last ran or was queued.
  logic [wpps_pkg::WAIT_W-1:0] wait_mem [JOB_COUNT];
  logic [wpps_pkg::TIME_W-1:0] lre_mem  [JOB_COUNT];
  logic [wpps_pkg::WAIT_W-1:0] wait_rd_q;
  logic [wpps_pkg::TIME_W-1:0] lre_rd_q;
  logic [JOB_COUNT-1:0]        wait_vld_q;
  logic                        jm_re, wait_we, lre_we;
  logic [JIW-1:0]              jm_raddr, wait_waddr, lre_waddr;
  logic [wpps_pkg::WAIT_W-1:0] wait_wdata;
  logic [wpps_pkg::TIME_W-1:0] lre_wdata;

  // Shared key unit.
  wpps_pkg::mac_ctrl_t               mac_ctrl;
  logic [wpps_pkg::BURST_W-1:0]      mac_opa;
  logic signed [wpps_pkg::WEIGHT_W-1:0] mac_w;
  logic signed [wpps_pkg::KEY_W-1:0] key;

  // Tick arithmetic.
  logic [JIW-1:0]                head_job;
  logic [wpps_pkg::WAIT_W-1:0]   wait_cur;
  logic [wpps_pkg::TIME_W-1:0]   gap;
  logic [wpps_pkg::WAIT_W:0]     wait_sum;
  logic [wpps_pkg::WAIT_W-1:0]   wait_sat;

  logic in_acc;

  wpps_key_mac u_key_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .opa_i    (mac_opa),
    .weight_i (mac_w),
    .key_o    (key)
  );

  // The block takes a new transaction whenever the sequencer is idle; a
  // result still waiting in the output register does not hold it back.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Waiting time of the head job, added with saturation.
  assign head_job = JIW'(q_rd_q.job);
  assign wait_cur = wait_vld_q[head_job] ? wait_rd_q : '0;
  assign gap      = time_q - lre_rd_q;
  assign wait_sum = {1'b0, wait_cur} + {1'b0, gap};
  assign wait_sat = wait_sum[wpps_pkg::WAIT_W] ? '1 : wait_sum[wpps_pkg::WAIT_W-1:0];

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    count_d    = count_q;
    head_d     = head_q;
    pos_d      = pos_q;
    j_d        = j_q;
    time_d     = time_q;
    prev_d     = prev_q;
    any_d      = any_q;
    newkey_d   = newkey_q;
    out_load   = 1'b0;
    out_d      = out_q;
    mac_ctrl   = '0;
    mac_opa    = '0;
    mac_w      = '0;
    q_re       = 1'b0;
    q_raddr    = head_q;
    q_we       = 1'b0;
    q_waddr    = head_q;
    q_wdata    = q_rd_q;
    jm_re      = 1'b0;
    jm_raddr   = head_job;
    wait_we    = 1'b0;
    wait_waddr = head_job;
    wait_wdata = wait_sat;
    lre_we     = 1'b0;
    lre_waddr  = head_job;
    lre_wdata  = time_q + wpps_pkg::TIME_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_d = in_data_i;
          if (in_data_i.mode == wpps_pkg::MODE_TICK) begin
            state_d = (count_q == '0) ? S_FIN : S_TRD;
          end else if (count_q == CW'(QUEUE_DEPTH) ||
                       32'(in_data_i.job_id) >= JOB_COUNT) begin
            state_d = S_FIN;
          end else begin
            state_d = S_NKEY0;
          end
        end
      end
      // Key of the arriving job: burst product, then priority product.
      S_NKEY0: begin
        mac_ctrl.mul_en = 1'b1;
        mac_opa         = item_q.burst_len;
        mac_w           = $signed(wb_q);
        state_d         = S_NKEY1;
      end
      S_NKEY1: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        mac_opa         = wpps_pkg::BURST_W'(item_q.job_priority);
        mac_w           = $signed(wp_q);
        state_d         = S_NKEY2;
      end
      S_NKEY2: begin
        newkey_d = key;
        pos_d    = '0;
        if (count_q == '0) begin
          j_d     = '0;
          state_d = S_SHRD;
        end else begin
          q_re    = 1'b1;
          q_raddr = phys(head_q, '0);
          state_d = S_SMUL0;
        end
      end
      // Scan from the head for the first entry with a smaller key.
      S_SMUL0: begin
        mac_ctrl.mul_en = 1'b1;
        mac_opa         = q_rd_q.rem;
        mac_w           = $signed(wb_q);
        state_d         = S_SMUL1;
      end
      S_SMUL1: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        mac_opa         = wpps_pkg::BURST_W'(q_rd_q.prio);
        mac_w           = $signed(wp_q);
        state_d         = S_SCMP;
      end
      S_SCMP: begin
        if (key >= newkey_q) begin
          pos_d = pos_q + QIW'(1);
          if (CW'(pos_q) + CW'(1) == count_q) begin
            j_d     = QIW'(count_q);
            state_d = S_SHRD;
          end else begin
            q_re    = 1'b1;
            q_raddr = phys(head_q, pos_q + QIW'(1));
            state_d = S_SMUL0;
          end
        end else begin
          j_d     = QIW'(count_q);
          state_d = S_SHRD;
        end
      end
      // Move the entries behind the insertion point back by one, tail first.
      S_SHRD: begin
        if (j_q == pos_q) begin
          state_d = S_INS;
        end else begin
          q_re    = 1'b1;
          q_raddr = phys(head_q, j_q - QIW'(1));
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        q_we    = 1'b1;
        q_waddr = phys(head_q, j_q);
        q_wdata = q_rd_q;
        j_d     = j_q - QIW'(1);
        state_d = S_SHRD;
      end
      S_INS: begin
        if (out_free) begin
          q_we         = 1'b1;
          q_waddr      = phys(head_q, pos_q);
          q_wdata.job  = item_q.job_id;
          q_wdata.rem  = item_q.burst_len;
          q_wdata.prio = item_q.job_priority;
          count_d      = count_q + CW'(1);
          lre_we       = 1'b1;
          lre_waddr    = JIW'(item_q.job_id);
          lre_wdata    = time_q;
          out_load     = 1'b1;
          out_d        = '0;
          out_d.status   = wpps_pkg::ST_QUEUED;
          out_d.end_time = time_q;
          state_d      = S_IDLE;
        end
      end
      // Tick: fetch the head entry, then its job's stores.
      S_TRD: begin
        q_re    = 1'b1;
        q_raddr = phys(head_q, '0);
        state_d = S_TJOB;
      end
      S_TJOB: begin
        jm_re    = 1'b1;
        jm_raddr = head_job;
        state_d  = S_TUPD;
      end
      S_TUPD: begin
        if (out_free) begin
          wait_we  = 1'b1;
          lre_we   = 1'b1;
          out_d    = '0;
          if (q_rd_q.rem <= wpps_pkg::BURST_W'(1)) begin
            head_d         = phys(head_q, QIW'(1));
            count_d        = count_q - CW'(1);
            out_d.job_done = 1'b1;
          end else begin
            q_we     = 1'b1;
            q_waddr  = phys(head_q, '0);
            q_wdata.rem = q_rd_q.rem - wpps_pkg::BURST_W'(1);
          end
          out_d.status      = wpps_pkg::ST_SERVED;
          out_d.served_id   = q_rd_q.job;
          out_d.wait_total  = wait_sat;
          out_d.end_time    = time_q + wpps_pkg::TIME_W'(1);
          out_d.new_segment = !any_q || (prev_q != q_rd_q.job);
          prev_d   = q_rd_q.job;
          any_d    = 1'b1;
          time_d   = time_q + wpps_pkg::TIME_W'(1);
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      // Dropped arrival or tick with an empty queue.
      S_FIN: begin
        if (out_free) begin
          out_d = '0;
          if (item_q.mode == wpps_pkg::MODE_TICK) begin
            out_d.status   = wpps_pkg::ST_IDLE;
            out_d.end_time = time_q + wpps_pkg::TIME_W'(1);
            time_d         = time_q + wpps_pkg::TIME_W'(1);
          end else begin
            out_d.status   = wpps_pkg::ST_DROPPED;
            out_d.end_time = time_q;
          end
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      time_q      <= '0;
      prev_q      <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
      wait_vld_q  <= '0;
      wb_q        <= wpps_pkg::WEIGHT_RESET;
      wp_q        <= wpps_pkg::WEIGHT_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      time_q  <= time_d;
      prev_q  <= prev_d;
      any_q   <= any_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (wait_we) begin
        wait_vld_q[wait_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wpps_pkg::CFG_WEIGHT_BURST: wb_q <= cfg_data_i;
          wpps_pkg::CFG_WEIGHT_PRIO:  wp_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    pos_q    <= pos_d;
    j_q      <= j_d;
    newkey_q <= newkey_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_q <= q_mem[q_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wait_we) begin
      wait_mem[wait_waddr] <= wait_wdata;
    end
    if (jm_re) begin
      wait_rd_q <= wait_mem[jm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lre_we) begin
      lre_mem[lre_waddr] <= lre_wdata;
    end
    if (jm_re) begin
      lre_rd_q <= lre_mem[jm_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/wpps_key_mac.sv
// Shared key unit: one signed multiply per cycle while mul_en is set into a product register, and
// the key formed as the sum of the held and the latest product.
module wpps_key_mac (
  input  logic                                clk_i,
  input  wpps_pkg::mac_ctrl_t                 ctrl_i,
  input  logic [wpps_pkg::BURST_W-1:0]        opa_i,
  input  logic signed [wpps_pkg::WEIGHT_W-1:0] weight_i,
  output logic signed [wpps_pkg::KEY_W-1:0]   key_o
);

  logic signed [wpps_pkg::BURST_W:0]   opa_s;
  logic signed [wpps_pkg::KEY_W-1:0]   prod_d;
  logic signed [wpps_pkg::KEY_W-1:0]   prod_q;
  logic signed [wpps_pkg::KEY_W-1:0]   acc_q;

  assign opa_s  = $signed({1'b0, opa_i});
  assign prod_d = opa_s * weight_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= prod_q;
    end
  end

  assign key_o = acc_q + prod_q;

endmodule
